@@ rtl/smx_pkg.sv @@
// ----------------------------------------------------------------------------
// smx_pkg
// Shared types and codes for the 128-bit SIMD extended multiply, rounding
// average and byte shuffle unit.
// ----------------------------------------------------------------------------
package smx_pkg;

	// vector and operand widths
	localparam int unsigned VEC_W   = 128;
	localparam int unsigned HALF_W  = 64;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned NBYTES  = VEC_W / BYTE_W;
	localparam int unsigned IDX_W   = 5;
	localparam int unsigned IN_DATA_W = 6 * HALF_W;
	localparam int unsigned IN_USER_W = 6;

	// command codes
	typedef enum logic [1:0] {
		CMD_EXTMUL  = 2'd0,
		CMD_AVGR    = 2'd1,
		CMD_SHUFFLE = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	// source lane size codes
	localparam logic [1:0] SIZE_BYTE = 2'd0;
	localparam logic [1:0] SIZE_HALF = 2'd1;
	localparam logic [1:0] SIZE_WORD = 2'd2;
	localparam logic [1:0] SIZE_WIDE = 2'd3;

	// control that travels down the pipeline with each item
	typedef struct packed {
		cmd_t       cmd;
		logic [1:0] lane_size;
	} ctrl_t;

endpackage

@@ rtl/simd128_extmul_avgr_shuffle_unit.sv @@
// ----------------------------------------------------------------------------
// simd128_extmul_avgr_shuffle_unit
// Stateless 128-bit SIMD unit: widening multiply, rounding average and byte
// shuffle over two vector operands.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one instruction per transfer. s_tdata carries both
//   operands and the shuffle indices, s_tuser carries the command, lane size
//   and the signed and upper-half flags.
//   Output channel m_*: one 128-bit result per instruction, in order.
//   On the way from input transfer to m_tvalid, stage 1 selects and extends
//   operands and forms the average and shuffle results, stage 2 runs the
//   lane multipliers, stage 3 picks the result into the output register.
//   Throughput is one instruction per cycle while the receiver does not
//   stall; the multiplier stage sets the clock.
//   Each stage holds its item while the stage behind it is full and stalled,
//   so a stall by the receiver backs up stage by stage and nothing is lost
//   or repeated; empty stages keep accepting.
//   Reset clears all valid bits; the unit is ready straight after reset.
// ----------------------------------------------------------------------------
module simd128_extmul_avgr_shuffle_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// a_lo, a_hi, b_lo, b_hi, sel_lo, sel_hi (64 bits each, from bit 0 up)
	input  logic [smx_pkg::IN_DATA_W-1:0]   s_tdata,
	// cmd[1:0], lane_size[3:2], signed_mode[4], upper_half[5]
	input  logic [smx_pkg::IN_USER_W-1:0]   s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// result_lo[63:0], result_hi[127:64]
	output logic [smx_pkg::VEC_W-1:0]       m_tdata
);

	localparam int unsigned HW = smx_pkg::HALF_W;

	// unpack the input transfer
	logic [smx_pkg::VEC_W-1:0]  vec_a, vec_b, vec_sel;
	logic [2*smx_pkg::VEC_W-1:0] both;
	logic [HW-1:0]              half_a, half_b;
	smx_pkg::ctrl_t             ctrl_in;
	logic                       sgn, upper;

	assign vec_a   = s_tdata[2*HW-1:0];
	assign vec_b   = s_tdata[4*HW-1:2*HW];
	assign vec_sel = s_tdata[6*HW-1:4*HW];
	assign both    = {vec_b, vec_a};
	assign ctrl_in.cmd       = smx_pkg::cmd_t'(s_tuser[1:0]);
	assign ctrl_in.lane_size = s_tuser[3:2];
	assign sgn     = s_tuser[4];
	assign upper   = s_tuser[5];
	assign half_a  = upper ? vec_a[2*HW-1:HW] : vec_a[HW-1:0];
	assign half_b  = upper ? vec_b[2*HW-1:HW] : vec_b[HW-1:0];

	// pipeline handshake: a stage takes a new item when empty or draining
	logic valid_s1, valid_s2, valid_s3;
	logic ready_s1, ready_s2, ready_s3;

	assign ready_s3 = !valid_s3 || m_tready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign s_tready = ready_s1;
	assign m_tvalid = valid_s3;

	// stage 1 logic: extend lanes, form average and shuffle results
	logic signed [32:0] wa_d [2];
	logic signed [32:0] wb_d [2];
	logic signed [16:0] ha_d [4];
	logic signed [16:0] hb_d [4];
	logic signed [8:0]  ba_d [8];
	logic signed [8:0]  bb_d [8];
	logic [smx_pkg::VEC_W-1:0] avg8, avg16, shuf, other_d;

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			wa_d[i] = {sgn & half_a[32*i+31], half_a[32*i +: 32]};
			wb_d[i] = {sgn & half_b[32*i+31], half_b[32*i +: 32]};
		end
		for (int i = 0; i < 4; i++) begin
			ha_d[i] = {sgn & half_a[16*i+15], half_a[16*i +: 16]};
			hb_d[i] = {sgn & half_b[16*i+15], half_b[16*i +: 16]};
		end
		for (int i = 0; i < 8; i++) begin
			ba_d[i] = {sgn & half_a[8*i+7], half_a[8*i +: 8]};
			bb_d[i] = {sgn & half_b[8*i+7], half_b[8*i +: 8]};
		end
	end

	always_comb begin
		logic [8:0]  s8;
		logic [16:0] s16;
		logic [smx_pkg::IDX_W-1:0] idx;
		for (int i = 0; i < 16; i++) begin
			s8 = {1'b0, vec_a[8*i +: 8]} + {1'b0, vec_b[8*i +: 8]} + 9'd1;
			avg8[8*i +: 8] = s8[8:1];
		end
		for (int i = 0; i < 8; i++) begin
			s16 = {1'b0, vec_a[16*i +: 16]} + {1'b0, vec_b[16*i +: 16]} + 17'd1;
			avg16[16*i +: 16] = s16[16:1];
		end
		for (int i = 0; i < smx_pkg::NBYTES; i++) begin
			idx = vec_sel[8*i +: smx_pkg::IDX_W];
			shuf[8*i +: 8] = both[8*idx +: 8];
		end
	end

	always_comb begin
		unique case (ctrl_in.cmd)
			smx_pkg::CMD_AVGR:    other_d = (ctrl_in.lane_size == smx_pkg::SIZE_BYTE)
				? avg8 : avg16;
			smx_pkg::CMD_SHUFFLE: other_d = shuf;
			smx_pkg::CMD_EXTMUL:  other_d = '0;
			smx_pkg::CMD_NONE:    other_d = '0;
		endcase
	end

	// stage 1 registers
	smx_pkg::ctrl_t            ctrl_s1;
	logic signed [32:0]        wa_s1 [2];
	logic signed [32:0]        wb_s1 [2];
	logic signed [16:0]        ha_s1 [4];
	logic signed [16:0]        hb_s1 [4];
	logic signed [8:0]         ba_s1 [8];
	logic signed [8:0]         bb_s1 [8];
	logic [smx_pkg::VEC_W-1:0] other_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1) begin
			ctrl_s1  <= ctrl_in;
			wa_s1    <= wa_d;
			wb_s1    <= wb_d;
			ha_s1    <= ha_d;
			hb_s1    <= hb_d;
			ba_s1    <= ba_d;
			bb_s1    <= bb_d;
			other_s1 <= other_d;
		end
	end

	// stage 2 logic: lane multipliers
	logic [63:0] pw_d [2];
	logic [31:0] ph_d [4];
	logic [15:0] pb_d [8];

	always_comb begin
		logic signed [65:0] pw;
		logic signed [33:0] ph;
		logic signed [17:0] pb;
		for (int i = 0; i < 2; i++) begin
			pw = 66'(wa_s1[i]) * 66'(wb_s1[i]);
			pw_d[i] = pw[63:0];
		end
		for (int i = 0; i < 4; i++) begin
			ph = 34'(ha_s1[i]) * 34'(hb_s1[i]);
			ph_d[i] = ph[31:0];
		end
		for (int i = 0; i < 8; i++) begin
			pb = 18'(ba_s1[i]) * 18'(bb_s1[i]);
			pb_d[i] = pb[15:0];
		end
	end

	// stage 2 registers
	smx_pkg::ctrl_t            ctrl_s2;
	logic [63:0]               pw_s2 [2];
	logic [31:0]               ph_s2 [4];
	logic [15:0]               pb_s2 [8];
	logic [smx_pkg::VEC_W-1:0] other_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2) begin
			ctrl_s2  <= ctrl_s1;
			pw_s2    <= pw_d;
			ph_s2    <= ph_d;
			pb_s2    <= pb_d;
			other_s2 <= other_s1;
		end
	end

	// stage 3 logic: pick the result
	logic [smx_pkg::VEC_W-1:0] res_d;

	always_comb begin
		res_d = other_s2;
		if (ctrl_s2.cmd == smx_pkg::CMD_EXTMUL) begin
			unique case (ctrl_s2.lane_size)
				smx_pkg::SIZE_BYTE: begin
					for (int i = 0; i < 8; i++) res_d[16*i +: 16] = pb_s2[i];
				end
				smx_pkg::SIZE_HALF: begin
					for (int i = 0; i < 4; i++) res_d[32*i +: 32] = ph_s2[i];
				end
				smx_pkg::SIZE_WORD, smx_pkg::SIZE_WIDE: begin
					for (int i = 0; i < 2; i++) res_d[64*i +: 64] = pw_s2[i];
				end
			endcase
		end
	end

	// stage 3: output register
	logic [smx_pkg::VEC_W-1:0] res_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3) begin
			res_s3 <= res_d;
		end
	end

	assign m_tdata = res_s3;

	// checks
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input not ready while receiver takes results");

	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && ctrl_s2.cmd == smx_pkg::CMD_NONE) |-> (res_d == '0))
		else $error("unused command gives a non-zero result");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !ready_s2) |=> (valid_s2 && $stable(other_s2)
			&& $stable(ctrl_s2)))
		else $error("stalled stage 2 item changed");

endmodule

@@ tb/simd_unit_checker.sv @@
// ----------------------------------------------------------------------------
// simd_unit_checker
// Watches both stream channels of the SIMD unit. Each instruction transfer
// is turned into its expected 128-bit result, which waits in order until
// the matching result transfer arrives and is compared half by half.
// ----------------------------------------------------------------------------
module simd_unit_checker
	import smx_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [IN_USER_W-1:0]  s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [VEC_W-1:0]      m_tdata,
	output int                    mismatch_count,
	output int                    pending,
	output int                    checked_count
);

	logic [VEC_W-1:0] results_due[$];
	int n_fail;
	int n_checked;

	// Work out the 128-bit result of one instruction
	function automatic logic [VEC_W-1:0] simd_result(cmd_t op, logic [1:0] size,
			logic sgn, logic upper, logic [VEC_W-1:0] va, logic [VEC_W-1:0] vb,
			logic [VEC_W-1:0] sel);
		logic [VEC_W-1:0] res;
		logic [2*VEC_W-1:0] pool;
		logic [63:0] x, y, msk, sbit, wmsk, lane;
		logic [IDX_W-1:0] idx;
		int lw, nl, base, i;
		res = '0;
		pool = {vb, va};
		case (op)
			CMD_EXTMUL: begin
				// word lanes for both of the two widest size codes
				lw = (size == SIZE_BYTE) ? 8 : (size == SIZE_HALF) ? 16 : 32;
				nl = 64 / lw;
				base = upper ? nl : 0;
				msk = (64'd1 << lw) - 64'd1;
				sbit = 64'd1 << (lw - 1);
				wmsk = (lw == 32) ? '1 : (64'd1 << (2 * lw)) - 64'd1;
				for (i = 0; i < nl; i++) begin
					x = 64'(va >> ((base + i) * lw)) & msk;
					y = 64'(vb >> ((base + i) * lw)) & msk;
					if (sgn) begin
						x = (x ^ sbit) - sbit;
						y = (y ^ sbit) - sbit;
					end
					lane = (x * y) & wmsk;
					res = res | ({64'd0, lane} << (i * 2 * lw));
				end
			end
			CMD_AVGR: begin
				// any size code other than byte means halfword lanes
				lw = (size == SIZE_BYTE) ? 8 : 16;
				msk = (64'd1 << lw) - 64'd1;
				for (i = 0; i < VEC_W / lw; i++) begin
					x = 64'(va >> (i * lw)) & msk;
					y = 64'(vb >> (i * lw)) & msk;
					lane = ((x + y + 64'd1) >> 1) & msk;
					res = res | ({64'd0, lane} << (i * lw));
				end
			end
			CMD_SHUFFLE: begin
				// index bits above the low five are dropped
				for (i = 0; i < NBYTES; i++) begin
					idx = sel[i * BYTE_W +: IDX_W];
					res[i * BYTE_W +: BYTE_W] = pool[int'(idx) * BYTE_W +: BYTE_W];
				end
			end
			default: res = '0;
		endcase
		return res;
	endfunction

	// Compare result transfers first, then queue the new instruction
	always @(posedge clk) begin : watch
		logic [VEC_W-1:0] due;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (results_due.size() == 0) begin
					n_fail++;
					$display("%0t: unexpected result, expected none, got %h",
						$time, m_tdata);
				end else begin
					due = results_due.pop_front();
					n_checked++;
					if (m_tdata[63:0] !== due[63:0]) begin
						n_fail++;
						$display("%0t: result_lo mismatch, expected %h, got %h",
							$time, due[63:0], m_tdata[63:0]);
					end
					if (m_tdata[127:64] !== due[127:64]) begin
						n_fail++;
						$display("%0t: result_hi mismatch, expected %h, got %h",
							$time, due[127:64], m_tdata[127:64]);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				results_due.push_back(simd_result(cmd_t'(s_tuser[1:0]), s_tuser[3:2],
					s_tuser[4], s_tuser[5], s_tdata[127:0], s_tdata[255:128],
					s_tdata[383:256]));
			end
		end
		mismatch_count <= n_fail;
		checked_count <= n_checked;
		pending <= results_due.size();
	end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives instructions into the SIMD unit: a directed set of edge cases for
// every command, then random instructions under four pacing phases of the
// sender and the receiver. The checker beside the unit scores each result.
// ----------------------------------------------------------------------------
module tb_top;
	import smx_pkg::*;

	localparam int CYCLE_LIMIT    = 200000;
	localparam int DRAIN_CYCLES   = 16;
	localparam int ITEMS_PER_PHASE = 108;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic [IN_USER_W-1:0] s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [VEC_W-1:0]     m_tdata;

	int mismatch_count;
	int pending;
	int checked_count;
	int send_idle_pct = 0;
	int sink_stall_pct = 0;
	int cycle_cnt = 0;
	int op_count[4];

	always #4 clk = ~clk;

	simd128_extmul_avgr_shuffle_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	simd_unit_checker result_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.mismatch_count (mismatch_count),
		.pending        (pending),
		.checked_count  (checked_count)
	);

	// Receiver: stall at random at the rate of the current phase
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
	end

	// Give up after a generous number of cycles
	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("simulation failed");
		$finish;
	end

	// Offer one instruction, after random idle cycles, and hold it until transfer
	task automatic send_instr(cmd_t op, logic [1:0] size, logic sgn, logic upper,
			logic [63:0] a_lo, logic [63:0] a_hi, logic [63:0] b_lo,
			logic [63:0] b_hi, logic [63:0] sel_lo, logic [63:0] sel_hi);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tuser <= IN_USER_W'($urandom);
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {sel_hi, sel_lo, b_hi, b_lo, a_hi, a_lo};
		s_tuser <= {upper, sgn, size, op};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		op_count[int'(op)]++;
	endtask

	// Hold the sender off until every outstanding result has come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Operand half, biased towards lane extremes
	function automatic logic [63:0] rand_half();
		case ($urandom_range(0, 11))
			0: return '0;
			1: return '1;
			2: return {8{8'h80}};
			3: return {8{8'h7f}};
			4: return {4{16'h8000}};
			5: return {2{32'h8000_0000}};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic send_random();
		int pick;
		cmd_t op;
		pick = $urandom_range(0, 15);
		op = (pick < 5) ? CMD_EXTMUL : (pick < 10) ? CMD_AVGR :
			(pick < 15) ? CMD_SHUFFLE : CMD_NONE;
		send_instr(op, 2'($urandom), 1'($urandom), 1'($urandom), rand_half(),
			rand_half(), rand_half(), rand_half(), {$urandom, $urandom},
			{$urandom, $urandom});
	endtask

	initial begin
		// hold reset, then release it
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// widening multiply: all-ones lanes, every size code, both signs
		for (int sz = 0; sz < 4; sz++) begin
			for (int sg = 0; sg < 2; sg++) begin
				send_instr(CMD_EXTMUL, sz[1:0], sg[0], sz[0] ^ sg[0], '1, '1, '1, '1,
					{$urandom, $urandom}, {$urandom, $urandom});
			end
		end
		// most negative times itself in the low half, times most positive above
		for (int up = 0; up < 2; up++) begin
			send_instr(CMD_EXTMUL, SIZE_BYTE, 1'b1, up[0], {8{8'h80}}, {8{8'h7f}},
				{8{8'h80}}, {8{8'h80}}, '0, '1);
			send_instr(CMD_EXTMUL, SIZE_HALF, 1'b1, up[0], {4{16'h8000}},
				{4{16'h7fff}}, {4{16'h8000}}, {4{16'h8000}}, '1, '0);
			send_instr(CMD_EXTMUL, SIZE_WORD, 1'b1, up[0], {2{32'h8000_0000}},
				{2{32'h7fff_ffff}}, {2{32'h8000_0000}}, {2{32'h8000_0000}}, '0, '0);
		end
		// rounding average: carry out of the lane, and every size code
		send_instr(CMD_AVGR, SIZE_BYTE, 1'b1, 1'b1, '1, '0, '1, '1, '1, '1);
		send_instr(CMD_AVGR, SIZE_HALF, 1'b0, 1'b0, '1, '1, '0, '1, '0, '0);
		send_instr(CMD_AVGR, SIZE_WORD, 1'b0, 1'b1, '1, '1, '1, '1, '1, '0);
		send_instr(CMD_AVGR, SIZE_WIDE, 1'b1, 1'b0, 64'h0001_ffff_8000_7fff, '1,
			64'h0000_fffe_8001_8000, '0, '0, '1);
		// shuffle: high index bits set, indices into b reversed, all ones
		send_instr(CMD_SHUFFLE, SIZE_BYTE, 1'b0, 1'b0, 64'h0706050403020100,
			64'h0f0e0d0c0b0a0908, 64'h1716151413121110, 64'h1f1e1d1c1b1a1918,
			64'he7e6e5e4e3e2e1e0, 64'hefeeedecebeae9e8);
		send_instr(CMD_SHUFFLE, SIZE_WIDE, 1'b1, 1'b1, 64'h0706050403020100,
			64'h0f0e0d0c0b0a0908, 64'h1716151413121110, 64'h1f1e1d1c1b1a1918,
			64'h18191a1b1c1d1e1f, 64'h1011121314151617);
		send_instr(CMD_SHUFFLE, SIZE_HALF, 1'b1, 1'b0, '0, '0, '0, 64'hab00_0000_0000_0000,
			'1, '1);
		// reserved command gives zero
		send_instr(CMD_NONE, SIZE_WIDE, 1'b1, 1'b1, '1, '1, '1, '1, '1, '1);
		wait_drained();

		// random instructions under each pacing phase, draining in between
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  sink_stall_pct <= 0;  end
				1: begin send_idle_pct = 47; sink_stall_pct <= 0;  end
				2: begin send_idle_pct = 0;  sink_stall_pct <= 47; end
				default: begin send_idle_pct = 7; sink_stall_pct <= 7; end
			endcase
			repeat (ITEMS_PER_PHASE) send_random();
			wait_drained();
		end

		// let any stray result show up before the verdict
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d instructions: %0d widening multiply, %0d average,",
			op_count[0] + op_count[1] + op_count[2] + op_count[3], op_count[0],
			op_count[1]);
		$display("  %0d shuffle, %0d reserved; %0d results compared", op_count[2],
			op_count[3], checked_count);
		$display("  across back-to-back, sender-gap, receiver-stall and mixed pacing");
		if (mismatch_count == 0 && pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
